### rtl/sid_pkg.sv
// Shared widths, constants and the pipeline stage record of the signed divider.
package sid_pkg;

  localparam int unsigned DATA_WIDTH     = 32;
  localparam int unsigned BITS_PER_STAGE = 4;
  localparam int unsigned NUM_STAGES     = (DATA_WIDTH + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int unsigned CORE_WIDTH     = NUM_STAGES * BITS_PER_STAGE;
  // operand register, division stages, output register
  localparam int unsigned LATENCY        = NUM_STAGES + 2;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [CORE_WIDTH-1:0]        core_t;

  localparam data_t INT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam data_t INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic  valid;
    logic  neg;
    logic  dbz;
    core_t num;
    core_t rem;
    core_t den;
  } stage_t;

endpackage

### rtl/signed_integer_divider.sv
// The result strobe follows start through the operand register, the division stages and the output register.
// Throughput: one item per cycle; busy_o stays low, every division stage is its own register.
// Depth: one operand register, NUM_STAGES stages of BITS_PER_STAGE quotient bits, one output reg.
// Reset: rst_ni clears all valid bits asynchronously; items in flight are dropped.
// The result strobe valid_o lasts one cycle; the receiver cannot stall the pipeline.
module signed_integer_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  sid_pkg::data_t dividend_i,
  input  sid_pkg::data_t divisor_i,
  output logic           busy_o,
  output logic           valid_o,
  output sid_pkg::data_t quotient_o,
  output logic           div_by_zero_o
);

  sid_pkg::stage_t pipe [sid_pkg::NUM_STAGES+1];
  logic            accept;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  sid_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .stage_o    (pipe[0])
  );

  for (genvar g = 0; g < sid_pkg::NUM_STAGES; g++) begin : g_stage
    sid_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (pipe[g]),
      .stage_o (pipe[g+1])
    );
  end

  sid_post u_post (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_i       (pipe[sid_pkg::NUM_STAGES]),
    .valid_o       (valid_o),
    .quotient_o    (quotient_o),
    .div_by_zero_o (div_by_zero_o)
  );

endmodule

### rtl/sid_prep.sv
// Operand stage: takes magnitudes, result sign and the zero-divisor flag.
module sid_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  sid_pkg::data_t      dividend_i,
  input  sid_pkg::data_t      divisor_i,
  output sid_pkg::stage_t     stage_o
);

  logic [sid_pkg::DATA_WIDTH-1:0] a_mag;
  logic [sid_pkg::DATA_WIDTH-1:0] b_mag;
  logic                           valid_d, valid_q;
  sid_pkg::stage_t                pay_d, pay_q;

  // the minimum value maps to its true unsigned magnitude
  assign a_mag = dividend_i[sid_pkg::DATA_WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign b_mag = divisor_i[sid_pkg::DATA_WIDTH-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  always_comb begin
    valid_d     = accept_i;
    pay_d       = '0;
    pay_d.valid = accept_i;
    pay_d.neg   = dividend_i[sid_pkg::DATA_WIDTH-1] ^ divisor_i[sid_pkg::DATA_WIDTH-1];
    pay_d.dbz   = (divisor_i == '0);
    pay_d.num   = sid_pkg::core_t'(a_mag);
    pay_d.rem   = '0;
    pay_d.den   = sid_pkg::core_t'(b_mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    stage_o       = pay_q;
    stage_o.valid = valid_q;
  end

endmodule

### rtl/sid_stage.sv
// One division stage: BITS_PER_STAGE restoring shift-and-subtract steps, then a register.
module sid_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sid_pkg::stage_t stage_i,
  output sid_pkg::stage_t stage_o
);

  logic            valid_q;
  sid_pkg::stage_t pay_d, pay_q;

  always_comb begin
    sid_pkg::core_t               num;
    sid_pkg::core_t               rem;
    logic [sid_pkg::CORE_WIDTH:0] diff;
    num  = stage_i.num;
    rem  = stage_i.rem;
    diff = '0;
    for (int k = 0; k < sid_pkg::BITS_PER_STAGE; k++) begin
      // bring down the next dividend bit, keep the quotient bit if the trial holds
      rem  = {rem[sid_pkg::CORE_WIDTH-2:0], num[sid_pkg::CORE_WIDTH-1]};
      num  = {num[sid_pkg::CORE_WIDTH-2:0], 1'b0};
      diff = {1'b0, rem} - {1'b0, stage_i.den};
      if (!diff[sid_pkg::CORE_WIDTH]) begin
        rem    = diff[sid_pkg::CORE_WIDTH-1:0];
        num[0] = 1'b1;
      end
    end
    pay_d     = stage_i;
    pay_d.num = num;
    pay_d.rem = rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  always_comb begin
    stage_o       = pay_q;
    stage_o.valid = valid_q;
  end

endmodule

### rtl/sid_post.sv
// Output stage: applies the sign, saturation and the zero-divisor result.
module sid_post (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sid_pkg::stage_t stage_i,
  output logic            valid_o,
  output sid_pkg::data_t  quotient_o,
  output logic            div_by_zero_o
);

  sid_pkg::data_t q_mag;
  sid_pkg::data_t quot_d, quot_q;
  logic           dbz_d, dbz_q;
  logic           valid_q;

  assign q_mag = stage_i.num[sid_pkg::DATA_WIDTH-1:0];

  always_comb begin
    dbz_d = stage_i.dbz;
    if (stage_i.dbz) begin
      quot_d = '0;
    end else if (stage_i.neg) begin
      quot_d = ~q_mag + 1'b1;
    end else if (q_mag[sid_pkg::DATA_WIDTH-1]) begin
      // minimum over minus one: clamp to the largest positive value
      quot_d = sid_pkg::INT_MAX;
    end else begin
      quot_d = q_mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    dbz_q  <= dbz_d;
  end

  assign valid_o       = valid_q;
  assign quotient_o    = quot_q;
  assign div_by_zero_o = dbz_q;

endmodule

### rtl/sid_checker.sv
// Port-level checker for the signed divider, bound to the top level.
module sid_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input sid_pkg::data_t dividend_i,
  input sid_pkg::data_t divisor_i,
  input logic           busy_o,
  input logic           valid_o,
  input sid_pkg::data_t quotient_o,
  input logic           div_by_zero_o
);

  // every result traces back to an earlier accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, sid_pkg::LATENCY))
    else $error("result without a matching item");

  // every accepted item gives its result
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(sid_pkg::LATENCY) valid_o)
    else $error("item lost in the pipeline");

  a_dbz_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (div_by_zero_o == ($past(divisor_i, sid_pkg::LATENCY) == '0)))
    else $error("zero-divisor flag does not match the item");

  a_dbz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && div_by_zero_o) |-> (quotient_o == '0))
    else $error("quotient not zero on zero divisor");

  // a nonzero quotient carries the sign of the operand signs combined
  a_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !div_by_zero_o && quotient_o != '0) |->
      (quotient_o[sid_pkg::DATA_WIDTH-1] ==
       $past(dividend_i[sid_pkg::DATA_WIDTH-1] ^ divisor_i[sid_pkg::DATA_WIDTH-1],
             sid_pkg::LATENCY)))
    else $error("quotient sign wrong");

endmodule

bind signed_integer_divider sid_checker u_sid_checker (.*);
